FILE: hw/rtl/hgag_pkg.sv
// ----------------------------------------------------------------------------
// hgag_pkg
// Shared types and constants of the Hangul glyph address generator.
// ----------------------------------------------------------------------------
package hgag_pkg;

    localparam logic [15:0] SYL_FIRST  = 16'hAC00;
    localparam logic [15:0] SYL_LAST   = 16'hD7A3;
    localparam logic [15:0] CHO_FIRST  = 16'h1100;
    localparam logic [15:0] CHO_LAST   = 16'h1112;
    localparam logic [15:0] JUNG_FIRST = 16'h1161;
    localparam logic [15:0] JUNG_LAST  = 16'h1175;
    localparam logic [15:0] JONG_FIRST = 16'h11A8;
    localparam logic [15:0] JONG_LAST  = 16'h11C2;

    // Number of slots per jamo class, the filler included.
    localparam int CHO_SLOTS  = 20;
    localparam int JUNG_SLOTS = 22;
    localparam int JONG_SLOTS = 28;

    localparam logic [7:0] JUNG_GLYPH_BASE = 8'd120;
    localparam logic [7:0] JONG_GLYPH_BASE = 8'd164;
    localparam logic [2:0] FINAL_KIND_ADD  = 3'd3;

    // Reciprocal multipliers: floor(x * RECIP / 2^SHIFT) equals x / divisor
    // over the whole range of x used here.
    localparam logic [14:0] RECIP28     = 15'd18725;
    localparam int          RECIP28_SH  = 19;
    localparam logic [8:0]  RECIP21     = 9'd391;
    localparam int          RECIP21_SH  = 13;

    typedef struct packed {
        logic       ok;
        logic [4:0] ini;
        logic [4:0] med;
        logic [4:0] fin;
    } idx_t;

    // Vowel class of the 6x2x1 font layout, indexed by medial index.
    function automatic logic [1:0] vowel_class(input logic [4:0] med);
        logic [1:0] cls;
        unique case (med)
            5'd9, 5'd13, 5'd14, 5'd18, 5'd19:         cls = 2'd1;
            5'd10, 5'd11, 5'd12, 5'd15, 5'd16, 5'd17,
            5'd20:                                   cls = 2'd2;
            default:                                 cls = 2'd0;
        endcase
        return cls;
    endfunction

endpackage

FILE: hw/rtl/hangul_glyph_address_gen_core.sv
// ----------------------------------------------------------------------------
// hangul_glyph_address_gen_core
// Splits a Unicode code point into Hangul jamo indices and font glyph numbers.
// ----------------------------------------------------------------------------
// Usage:
// A code point enters on the input channel (in_valid, in_stall, code_point).
// One result transaction leaves on the output channel (out_valid, out_stall)
// for every input transaction, in order. A syllable is split into initial,
// medial and final indices; a lone conjoining jamo sets one index; any other
// code gives valid_res low, zero indices and the filler glyph numbers.
// The byte offset of a glyph in the font is its glyph number times 32.
// There are five register stages; a code point passes through each in turn
// before out_valid rises for it. One code point is accepted every cycle
// while the output is not stalled. The five stages are:
// decode, divide by 28, remainder and divide by 21, index select, glyph map.
// Each stage takes new data when it is empty or the stage after it moves, so
// a stalled receiver fills the pipeline bubble by bubble before in_stall
// rises; nothing is lost or repeated. Reset empties the pipeline; the first
// code point can be accepted in the cycle after reset is released.
// ----------------------------------------------------------------------------
module hangul_glyph_address_gen_core
    import hgag_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] code_point,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        valid_res,
    output logic [4:0]  initial_index,
    output logic [4:0]  medial_index,
    output logic [4:0]  final_index,
    output logic [6:0]  cho_glyph,
    output logic [7:0]  jung_glyph,
    output logic [7:0]  jong_glyph
);

    logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;

    // Stage A: decode
    logic        a_valid_reg;
    logic        a_syl_reg, a_syl_next;
    logic [13:0] a_s_reg, a_s_next;
    idx_t        a_jamo_reg, a_jamo_next;

    // Stage B: quotient by 28
    logic        b_valid_reg;
    logic        b_syl_reg;
    logic [13:0] b_s_reg;
    logic [8:0]  b_q_reg, b_q_next;
    idx_t        b_jamo_reg;
    logic [28:0] b_prod;

    // Stage C: remainder by 28, quotient by 21
    logic        c_valid_reg;
    logic        c_syl_reg;
    logic [8:0]  c_q_reg;
    logic [4:0]  c_r_reg, c_r_next;
    logic [4:0]  c_q21_reg, c_q21_next;
    idx_t        c_jamo_reg;
    logic [13:0] c_q28;
    logic [17:0] c_prod;

    // Stage D: index select
    logic        d_valid_reg;
    idx_t        d_idx_reg, d_idx_next;
    logic [8:0]  d_q21x;
    logic [4:0]  d_rem21;

    // Stage E: output
    logic        e_valid_reg;
    idx_t        e_idx_reg;
    logic [6:0]  e_ig_reg, e_ig_next;
    logic [7:0]  e_mg_reg, e_mg_next;
    logic [7:0]  e_fg_reg, e_fg_next;

    assign rdy_e = !e_valid_reg || !out_stall;
    assign rdy_d = !d_valid_reg || rdy_e;
    assign rdy_c = !c_valid_reg || rdy_d;
    assign rdy_b = !b_valid_reg || rdy_c;
    assign rdy_a = !a_valid_reg || rdy_b;
    assign in_stall = !rdy_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a) a_valid_reg <= in_valid;
            if (rdy_b) b_valid_reg <= a_valid_reg;
            if (rdy_c) c_valid_reg <= b_valid_reg;
            if (rdy_d) d_valid_reg <= c_valid_reg;
            if (rdy_e) e_valid_reg <= d_valid_reg;
        end
    end

    // Stage A logic
    always_comb
    begin
        a_syl_next = (code_point >= SYL_FIRST) && (code_point <= SYL_LAST);
        a_s_next = 14'(code_point - SYL_FIRST);
        a_jamo_next = '0;
        a_jamo_next.ok = a_syl_next;
        if ((code_point >= CHO_FIRST) && (code_point <= CHO_LAST))
        begin
            a_jamo_next.ok = 1'b1;
            a_jamo_next.ini = 5'(code_point - CHO_FIRST) + 5'd1;
        end
        if ((code_point >= JUNG_FIRST) && (code_point <= JUNG_LAST))
        begin
            a_jamo_next.ok = 1'b1;
            a_jamo_next.med = 5'(code_point - JUNG_FIRST) + 5'd1;
        end
        if ((code_point >= JONG_FIRST) && (code_point <= JONG_LAST))
        begin
            a_jamo_next.ok = 1'b1;
            a_jamo_next.fin = 5'(code_point - JONG_FIRST) + 5'd1;
        end
    end

    // Stage B logic
    always_comb
    begin
        b_prod = {15'd0, a_s_reg} * {14'd0, RECIP28};
        b_q_next = b_prod[RECIP28_SH +: 9];
    end

    // Stage C logic
    always_comb
    begin
        c_q28 = ({5'd0, b_q_reg} << 5) - ({5'd0, b_q_reg} << 2);
        c_r_next = 5'(b_s_reg - c_q28);
        c_prod = {9'd0, b_q_reg} * {9'd0, RECIP21};
        c_q21_next = c_prod[RECIP21_SH +: 5];
    end

    // Stage D logic
    always_comb
    begin
        d_q21x = ({4'd0, c_q21_reg} << 4) + ({4'd0, c_q21_reg} << 2)
                 + {4'd0, c_q21_reg};
        d_rem21 = 5'(c_q_reg - d_q21x);
        if (c_syl_reg)
        begin
            d_idx_next.ok = 1'b1;
            d_idx_next.ini = c_q21_reg + 5'd1;
            d_idx_next.med = d_rem21 + 5'd1;
            d_idx_next.fin = c_r_reg;
        end
        else
        begin
            d_idx_next = c_jamo_reg;
        end
    end

    // Stage E logic
    hgag_glyph_calc u_glyph_calc (
        .idx        (d_idx_reg),
        .cho_glyph  (e_ig_next),
        .jung_glyph (e_mg_next),
        .jong_glyph (e_fg_next)
    );

    always_ff @(posedge clk)
    begin
        if (rdy_a)
        begin
            a_syl_reg  <= a_syl_next;
            a_s_reg    <= a_s_next;
            a_jamo_reg <= a_jamo_next;
        end
        if (rdy_b)
        begin
            b_syl_reg  <= a_syl_reg;
            b_s_reg    <= a_s_reg;
            b_q_reg    <= b_q_next;
            b_jamo_reg <= a_jamo_reg;
        end
        if (rdy_c)
        begin
            c_syl_reg  <= b_syl_reg;
            c_q_reg    <= b_q_reg;
            c_r_reg    <= c_r_next;
            c_q21_reg  <= c_q21_next;
            c_jamo_reg <= b_jamo_reg;
        end
        if (rdy_d)
        begin
            d_idx_reg <= d_idx_next;
        end
        if (rdy_e)
        begin
            e_idx_reg <= d_idx_reg;
            e_ig_reg  <= e_ig_next;
            e_mg_reg  <= e_mg_next;
            e_fg_reg  <= e_fg_next;
        end
    end

    assign out_valid     = e_valid_reg;
    assign valid_res     = e_idx_reg.ok;
    assign initial_index = e_idx_reg.ini;
    assign medial_index  = e_idx_reg.med;
    assign final_index   = e_idx_reg.fin;
    assign cho_glyph     = e_ig_reg;
    assign jung_glyph    = e_mg_reg;
    assign jong_glyph    = e_fg_reg;

`ifndef ASSERT_OFF
    // An empty decode stage must never push back on the sender.
    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !a_valid_reg |-> !in_stall)
        else $error("input stalled while decode stage is empty");

    // The reciprocal divide by 28 must leave a remainder below 28.
    c_rem28_range: assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && c_syl_reg) |-> (c_r_reg < 5'(JONG_SLOTS)))
        else $error("remainder by 28 out of range");

    // A syllable gives an initial index of at most 19.
    c_q21_range: assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && c_syl_reg) |-> (c_q21_reg <= 5'd18))
        else $error("quotient by 21 out of range");

    // A rejected code carries all-filler indices.
    out_reject_filler: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !valid_res) |->
            (initial_index == 5'd0 && medial_index == 5'd0 && final_index == 5'd0))
        else $error("rejected code with nonzero index");

    // An accepted code has at least one nonzero index.
    out_accept_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && valid_res) |->
            (initial_index != 5'd0 || medial_index != 5'd0 || final_index != 5'd0))
        else $error("accepted code with all indices zero");
`endif

endmodule

FILE: hw/rtl/hgag_glyph_calc.sv
// ----------------------------------------------------------------------------
// hgag_glyph_calc
// Maps jamo indices to glyph numbers by the 6x2x1 font rule.
// ----------------------------------------------------------------------------
module hgag_glyph_calc
    import hgag_pkg::*;
(
    input  idx_t       idx,
    output logic [6:0] cho_glyph,
    output logic [7:0] jung_glyph,
    output logic [7:0] jong_glyph
);

    logic       has_final;
    logic [2:0] ikind;

    always_comb
    begin
        has_final = (idx.fin != 5'd0);
        ikind = {1'b0, vowel_class(idx.med)} + (has_final ? FINAL_KIND_ADD : 3'd0);
        cho_glyph = 7'(ikind) * 7'(CHO_SLOTS) + {2'b00, idx.ini};
        jung_glyph = JUNG_GLYPH_BASE + (has_final ? 8'(JUNG_SLOTS) : 8'd0)
                     + {3'b000, idx.med};
        jong_glyph = JONG_GLYPH_BASE + {3'b000, idx.fin};
    end

endmodule
